>>> sv/bcdm_pkg.sv
// ----------------------------------------------------------------------------
// bcdm_pkg
// Types, constants and helpers for the block-cyclic device mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdm_pkg;

   localparam int MaxDevices = 16;
   localparam int CoordW     = 32;
   localparam int MaskW      = MaxDevices;
   localparam int DevW       = 4;
   localparam int CntW       = 5;
   localparam int RemW       = 4;
   localparam int DivW       = 5;
   localparam int ValW       = 8;
   localparam int StageBits  = 8;
   localparam int ModStages  = CoordW / StageBits;

   // Cell rule selected by the device count
   typedef enum logic [1:0] {
      MODE_ONE      = 2'd0,
      MODE_ROWMAJOR = 2'd1,
      MODE_ODD      = 2'd2,
      MODE_SQUARE   = 2'd3
   } mode_type;

   // Decoded cfg; user (not block) keeps stable while transactions are in flight
   typedef struct packed {
      logic [DivW-1:0]  n;
      logic [DivW-1:0]  rows;
      logic [DivW-1:0]  cols;
      logic [RemW-1:0]  step;
      mode_type         mode;
      logic [MaskW-1:0] limit;
   } cfg_type;

   // Payload travelling through the remainder stages
   typedef struct packed {
      logic [CoordW-1:0] row;
      logic [CoordW-1:0] col;
      logic [RemW-1:0]   rem_row;
      logic [RemW-1:0]   rem_col;
      logic [MaskW-1:0]  support;
      logic              fallback;
   } mod_type;

   // One result transaction
   typedef struct packed {
      logic             mapped;
      logic [DevW-1:0]  device_id;
      logic [MaskW-1:0] device_mask;
      logic [CntW-1:0]  candidate_count;
   } res_type;

   // One restoring remainder step: shift in a bit, subtract the divisor if it fits
   function automatic logic [RemW-1:0] rem_step(input logic [RemW-1:0] rem,
                                                input logic            din,
                                                input logic [DivW-1:0] divisor);
      logic [DivW-1:0] t;
      t = {rem, din};
      if (t >= divisor) begin
         t = t - divisor;
      end
      return t[RemW-1:0];
   endfunction

endpackage

`default_nettype wire

>>> sv/bcdm_cfg.sv
// ----------------------------------------------------------------------------
// bcdm_cfg
// Device count register and decode of grid shape, rule and device limit.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdm_cfg (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [bcdm_pkg::CntW-1:0] csr_device_count,
   output bcdm_pkg::cfg_type              cfg
);

   logic [bcdm_pkg::CntW-1:0] device_count_ff;
   logic [bcdm_pkg::CntW-1:0] device_count_in;
   logic [bcdm_pkg::DivW-1:0] n;
   logic [bcdm_pkg::MaskW:0]  limit_wide;

   assign csr_ready = 1'b1;

   always_comb begin
      device_count_in = device_count_ff;
      if (csr_valid) begin
         device_count_in = csr_device_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_count_ff <= bcdm_pkg::CntW'(1);
      end else begin
         device_count_ff <= device_count_in;
      end
   end

   // Clamp zero to one and large counts to the device limit
   always_comb begin
      n = device_count_ff;
      if (device_count_ff == '0) begin
         n = bcdm_pkg::DivW'(1);
      end else if (device_count_ff > bcdm_pkg::DivW'(bcdm_pkg::MaxDevices)) begin
         n = bcdm_pkg::DivW'(bcdm_pkg::MaxDevices);
      end
   end

   assign limit_wide = ((bcdm_pkg::MaskW+1)'(1) << n) - (bcdm_pkg::MaskW+1)'(1);

   always_comb begin
      cfg       = '0;
      cfg.n     = n;
      cfg.rows  = n;
      cfg.cols  = n;
      cfg.step  = bcdm_pkg::RemW'((n + bcdm_pkg::DivW'(1)) >> 1);
      cfg.limit = limit_wide[bcdm_pkg::MaskW-1:0];
      unique case (n)
         5'd1: begin
            cfg.mode = bcdm_pkg::MODE_ONE;
         end
         5'd4: begin
            cfg.mode = bcdm_pkg::MODE_SQUARE;
            cfg.rows = 5'd2;
            cfg.cols = 5'd2;
         end
         5'd9: begin
            cfg.mode = bcdm_pkg::MODE_SQUARE;
            cfg.rows = 5'd3;
            cfg.cols = 5'd3;
         end
         5'd6: begin
            cfg.mode = bcdm_pkg::MODE_ROWMAJOR;
            cfg.rows = 5'd3;
            cfg.cols = 5'd2;
         end
         5'd8: begin
            cfg.mode = bcdm_pkg::MODE_ROWMAJOR;
            cfg.rows = 5'd4;
            cfg.cols = 5'd2;
         end
         default: begin
            cfg.mode = n[0] ? bcdm_pkg::MODE_ODD : bcdm_pkg::MODE_SQUARE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> sv/bcdm_mod_stage.sv
// ----------------------------------------------------------------------------
// bcdm_mod_stage
// One pipeline stage of the coordinate remainders: eight bits of each lane.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdm_mod_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bcdm_pkg::cfg_type cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire bcdm_pkg::mod_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output bcdm_pkg::mod_type      out_data
);

   logic              valid_ff;
   bcdm_pkg::mod_type data_ff;
   bcdm_pkg::mod_type data_in;
   logic [bcdm_pkg::RemW-1:0] rr;
   logic [bcdm_pkg::RemW-1:0] rc;

   // Consume the top bits of each coordinate, most significant first
   always_comb begin
      rr = in_data.rem_row;
      rc = in_data.rem_col;
      for (int k = 0; k < bcdm_pkg::StageBits; k++) begin
         rr = bcdm_pkg::rem_step(rr, in_data.row[bcdm_pkg::CoordW-1-k], cfg.rows);
         rc = bcdm_pkg::rem_step(rc, in_data.col[bcdm_pkg::CoordW-1-k], cfg.cols);
      end
      data_in         = in_data;
      data_in.row     = in_data.row << bcdm_pkg::StageBits;
      data_in.col     = in_data.col << bcdm_pkg::StageBits;
      data_in.rem_row = rr;
      data_in.rem_col = rc;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/bcdm_entry.sv
// ----------------------------------------------------------------------------
// bcdm_entry
// Grid cell to device: rule value, reduction by the count, final result.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdm_entry (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bcdm_pkg::cfg_type cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire bcdm_pkg::mod_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output bcdm_pkg::res_type      out_data
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic ready1, ready2, ready3;

   logic [bcdm_pkg::ValW-1:0]  v1_ff, v1_in;
   logic [bcdm_pkg::RemW-1:0]  j1_ff;
   logic [bcdm_pkg::MaskW-1:0] mask1_ff;
   logic                       fb1_ff;

   logic [bcdm_pkg::RemW-1:0]  rem2_ff, rem2_in;
   logic [bcdm_pkg::RemW-1:0]  j2_ff;
   logic [bcdm_pkg::MaskW-1:0] mask2_ff;
   logic [bcdm_pkg::CntW-1:0]  cnt2_ff, cnt2_in;
   logic                       fb2_ff;

   bcdm_pkg::res_type          res3_ff, res3_in;

   logic [bcdm_pkg::ValW-1:0]  iw, jw;
   logic [bcdm_pkg::DivW-1:0]  shift, sum;
   logic [bcdm_pkg::DevW-1:0]  id;

   assign ready3   = !s3_valid_ff || out_ready;
   assign ready2   = !s2_valid_ff || ready3;
   assign ready1   = !s1_valid_ff || ready2;
   assign in_ready = ready1;

   // Rule value for the cell
   always_comb begin
      iw = {4'd0, in_data.rem_row};
      jw = {4'd0, in_data.rem_col};
      case (cfg.mode)
         bcdm_pkg::MODE_SQUARE: begin
            if (jw >= iw) begin
               v1_in = jw * jw + iw;
            end else begin
               v1_in = iw * (iw + 8'd2) - jw;
            end
         end
         bcdm_pkg::MODE_ODD: begin
            v1_in = iw * {4'd0, cfg.step};
         end
         bcdm_pkg::MODE_ROWMAJOR: begin
            v1_in = (iw << 1) + jw;
         end
         default: begin
            v1_in = '0;
         end
      endcase
   end

   // Reduce by the device count; count fallback candidates
   always_comb begin
      rem2_in = '0;
      for (int k = bcdm_pkg::ValW - 1; k >= 0; k--) begin
         rem2_in = bcdm_pkg::rem_step(rem2_in, v1_ff[k], cfg.n);
      end
      cnt2_in = '0;
      for (int k = 0; k < bcdm_pkg::MaskW; k++) begin
         cnt2_in = cnt2_in + bcdm_pkg::CntW'(mask1_ff[k]);
      end
   end

   // Odd counts shift row, add column with one wrap; others use the remainder
   always_comb begin
      shift = (rem2_ff == '0) ? '0 : cfg.n - {1'b0, rem2_ff};
      sum   = shift + {1'b0, j2_ff};
      if (sum >= cfg.n) begin
         sum = sum - cfg.n;
      end
      id = (cfg.mode == bcdm_pkg::MODE_ODD) ? sum[bcdm_pkg::DevW-1:0] : rem2_ff;
      if (fb2_ff) begin
         res3_in.mapped          = 1'b0;
         res3_in.device_id       = '0;
         res3_in.device_mask     = mask2_ff;
         res3_in.candidate_count = cnt2_ff;
      end else begin
         res3_in.mapped          = 1'b1;
         res3_in.device_id       = id;
         res3_in.device_mask     = bcdm_pkg::MaskW'(1) << id;
         res3_in.candidate_count = bcdm_pkg::CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (ready1) begin
            s1_valid_ff <= in_valid;
         end
         if (ready2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (ready3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         v1_ff    <= v1_in;
         j1_ff    <= in_data.rem_col;
         mask1_ff <= in_data.support & cfg.limit;
         fb1_ff   <= in_data.fallback;
      end
      if (ready2) begin
         rem2_ff  <= rem2_in;
         j2_ff    <= j1_ff;
         mask2_ff <= mask1_ff;
         cnt2_ff  <= cnt2_in;
         fb2_ff   <= fb1_ff;
      end
      if (ready3) begin
         res3_ff  <= res3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = res3_ff;

endmodule

`default_nettype wire

>>> sv/block_cyclic_device_mapper_top.sv
// ----------------------------------------------------------------------------
// block_cyclic_device_mapper_top
// Maps a task's block coordinates to one device of a block-cyclic grid, or
// falls back to the kernel support mask limited to the configured devices.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  row_index, column_index, support_mask
//   rsp_      out        rsp_valid/rsp_stall  mapped, device_id, device_mask,
//                                             candidate_count
//   csr_      in         csr_valid/csr_ready  device_count (always ready)
//
// Flow: one transaction enters per clock while req_stall is low; its result passes
// through four remainder stages of eight coordinate bits each, then rule value,
// reduction by the device count and result register.
// Reset: synchronous; clears all stage valid bits and sets the device count
// to one.
// Stalls: each stage holds while its successor is full and stalled, so empty
// stages fill up behind a stalled result and no transaction is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module block_cyclic_device_mapper_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [31:0]         req_row_index,
   input  wire logic signed [31:0]         req_column_index,
   input  wire logic        [15:0]         req_support_mask,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_mapped,
   output logic             [3:0]          rsp_device_id,
   output logic             [15:0]         rsp_device_mask,
   output logic             [4:0]          rsp_candidate_count,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic        [4:0]          csr_device_count
);

   bcdm_pkg::cfg_type cfg;
   bcdm_pkg::mod_type mod_data  [bcdm_pkg::ModStages+1];
   logic              mod_valid [bcdm_pkg::ModStages+1];
   logic              mod_ready [bcdm_pkg::ModStages+1];
   bcdm_pkg::res_type res;

   bcdm_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_device_count (csr_device_count),
      .cfg              (cfg)
   );

   // Launch the transaction: remainders start at zero, any negative
   // coordinate selects the fallback path
   always_comb begin
      mod_data[0].row      = req_row_index;
      mod_data[0].col      = req_column_index;
      mod_data[0].rem_row  = '0;
      mod_data[0].rem_col  = '0;
      mod_data[0].support  = req_support_mask;
      mod_data[0].fallback = req_row_index[31] | req_column_index[31];
   end

   assign mod_valid[0] = req_valid;
   assign req_stall    = !mod_ready[0];

   for (genvar s = 0; s < bcdm_pkg::ModStages; s++) begin : g_mod
      bcdm_mod_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .cfg       (cfg),
         .in_valid  (mod_valid[s]),
         .in_ready  (mod_ready[s]),
         .in_data   (mod_data[s]),
         .out_valid (mod_valid[s+1]),
         .out_ready (mod_ready[s+1]),
         .out_data  (mod_data[s+1])
      );
   end

   bcdm_entry u_entry (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mod_valid[bcdm_pkg::ModStages]),
      .in_ready  (mod_ready[bcdm_pkg::ModStages]),
      .in_data   (mod_data[bcdm_pkg::ModStages]),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (res)
   );

   // Drive the result ports from the result register
   assign rsp_mapped          = res.mapped;
   assign rsp_device_id       = res.device_id;
   assign rsp_device_mask     = res.device_mask;
   assign rsp_candidate_count = res.candidate_count;

   // A mapped result names exactly one device
   a_mapped_one_hot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mapped |-> rsp_device_mask == (16'd1 << rsp_device_id)
                                  && rsp_candidate_count == 5'd1)
      else $error("mapped result is not a single device");

   // A fallback result carries device zero and a consistent count
   a_fallback_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mapped |-> rsp_device_id == 4'd0
                                   && rsp_candidate_count == 5'($countones(rsp_device_mask)))
      else $error("fallback result inconsistent");

   // Back-pressure only reaches the input when the result register is full
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while pipeline has room");

   // The configuration port never blocks
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port not ready");

endmodule

`default_nettype wire

>>> test/bcdm_mapping_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcdm_mapping_checker
// Watches the task, result and register channels of the device mapper. It
// keeps a copy of the device count, predicts the device choice for every task
// taken in and compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------

module bcdm_mapping_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_row_index,
   input  logic [31:0] req_column_index,
   input  logic [15:0] req_support_mask,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_mapped,
   input  logic [3:0]  rsp_device_id,
   input  logic [15:0] rsp_device_mask,
   input  logic [4:0]  rsp_candidate_count,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [4:0]  csr_device_count,
   output int          fail_count,
   output int          outstanding,
   output int          checked_count,
   output int          mapped_count
);

   logic [4:0]        device_count_copy;
   bcdm_pkg::res_type pending_mappings [$];
   int                failures;
   int                checked;
   int                mapped;

   initial begin
      device_count_copy = 5'd1;
      failures          = 0;
      checked           = 0;
      mapped            = 0;
      fail_count        = 0;
      outstanding       = 0;
      checked_count     = 0;
      mapped_count      = 0;
   end

   // Device choice for one task under the given count register
   function automatic bcdm_pkg::res_type predict_mapping(input logic [4:0]  count_reg,
                                                         input logic [31:0] row,
                                                         input logic [31:0] col,
                                                         input logic [15:0] support);
      int unsigned        n;
      int unsigned        rows;
      int unsigned        cols;
      int unsigned        i;
      int unsigned        j;
      int unsigned        step;
      int unsigned        shift;
      int unsigned        id;
      bcdm_pkg::mode_type rule;
      logic [15:0]        limited;
      bcdm_pkg::res_type  res;
      n = count_reg;
      if (n == 0) n = 1;
      if (n > bcdm_pkg::MaxDevices) n = bcdm_pkg::MaxDevices;
      rows = n;
      cols = n;
      case (n)
         4: begin rows = 2; cols = 2; end
         9: begin rows = 3; cols = 3; end
         6: begin rows = 3; cols = 2; end
         8: begin rows = 4; cols = 2; end
         default: ;
      endcase
      if (n == 1) rule = bcdm_pkg::MODE_ONE;
      else if (n == 6 || n == 8) rule = bcdm_pkg::MODE_ROWMAJOR;
      else if ((n % 2) == 1 && n != 9) rule = bcdm_pkg::MODE_ODD;
      else rule = bcdm_pkg::MODE_SQUARE;

      if (!row[31] && !col[31]) begin
         i = row % rows;
         j = col % cols;
         case (rule)
            bcdm_pkg::MODE_ONE:      id = 0;
            bcdm_pkg::MODE_ROWMAJOR: id = i * 2 + j;
            bcdm_pkg::MODE_ODD: begin
               // each row is the cyclic sequence shifted back by i*step
               step  = (n + 1) / 2;
               shift = (n - ((i * step) % n)) % n;
               id    = (shift + j) % n;
            end
            default: id = (j >= i) ? (j * j + i) % n : (i * (i + 2) - j) % n;
         endcase
         res.mapped          = 1'b1;
         res.device_id       = 4'(id);
         res.device_mask     = 16'(1) << id[3:0];
         res.candidate_count = 5'd1;
      end else begin
         limited             = support & 16'((32'd1 << n) - 32'd1);
         res.mapped          = 1'b0;
         res.device_id       = '0;
         res.device_mask     = limited;
         res.candidate_count = 5'($countones(limited));
      end
      return res;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         failures++;
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
      end
   endtask

   always @(posedge clock) begin
      bcdm_pkg::res_type want;
      if (reset) begin
         device_count_copy = 5'd1;
         pending_mappings.delete();
      end else begin
         if (csr_valid && csr_ready) device_count_copy = csr_device_count;
         if (req_valid && !req_stall) begin
            pending_mappings.push_back(predict_mapping(device_count_copy, req_row_index,
                                                       req_column_index, req_support_mask));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_mappings.size() == 0) begin
               failures++;
               $error("result transaction with no task outstanding (device_id %0d)",
                      rsp_device_id);
            end else begin
               want = pending_mappings.pop_front();
               checked++;
               if (want.mapped) mapped++;
               check_field("mapped", want.mapped, rsp_mapped);
               check_field("device_id", want.device_id, rsp_device_id);
               check_field("device_mask", want.device_mask, rsp_device_mask);
               check_field("candidate_count", want.candidate_count, rsp_candidate_count);
            end
         end
      end
      fail_count    <= failures;
      outstanding   <= pending_mappings.size();
      checked_count <= checked;
      mapped_count  <= mapped;
   end

endmodule

>>> test/tb_block_cyclic_device_mapper_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_cyclic_device_mapper_top
// Drives tasks into the block-cyclic device mapper under many device counts,
// with bursty input and an irregular stalling receiver; a checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_block_cyclic_device_mapper_top;

   localparam int ItemsPerPhase = 55;
   localparam int HoldCycles    = 150;
   localparam int DrainCycles   = 16;
   localparam int CycleLimit    = 200000;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC,
      STALL_HOLD
   } stall_style_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_row_index;
   logic [31:0] req_column_index;
   logic [15:0] req_support_mask;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_mapped;
   logic [3:0]  rsp_device_id;
   logic [15:0] rsp_device_mask;
   logic [4:0]  rsp_candidate_count;
   logic        csr_valid;
   logic        csr_ready;
   logic [4:0]  csr_device_count;

   int fail_count;
   int outstanding;
   int checked_count;
   int mapped_count;
   int cycle_count;
   int burst_left = 0;
   bit hold_request = 1'b0;

   // Special counts first, then the rest; zero and everything above sixteen
   // must behave as one and sixteen devices respectively
   int unsigned count_settings [$] = '{4, 9, 6, 8, 0, 1, 2, 3, 5, 7,
                                       10, 11, 12, 13, 14, 15, 16, 17, 31, 24};

   always #2 clock = ~clock;

   block_cyclic_device_mapper_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_row_index       (req_row_index),
      .req_column_index    (req_column_index),
      .req_support_mask    (req_support_mask),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_mapped          (rsp_mapped),
      .rsp_device_id       (rsp_device_id),
      .rsp_device_mask     (rsp_device_mask),
      .rsp_candidate_count (rsp_candidate_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_device_count    (csr_device_count)
   );

   bcdm_mapping_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_row_index       (req_row_index),
      .req_column_index    (req_column_index),
      .req_support_mask    (req_support_mask),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_mapped          (rsp_mapped),
      .rsp_device_id       (rsp_device_id),
      .rsp_device_mask     (rsp_device_mask),
      .rsp_candidate_count (rsp_candidate_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_device_count    (csr_device_count),
      .fail_count          (fail_count),
      .outstanding         (outstanding),
      .checked_count       (checked_count),
      .mapped_count        (mapped_count)
   );

   // Offer one task and hold it until it is taken. A new burst starts with a
   // random gap (sometimes none), so gaps land at every point of the pipeline.
   // Called right after a rising edge; returns on the edge that accepts it.
   task automatic send_item(input logic [31:0] row, input logic [31:0] col,
                            input logic [15:0] support);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_row_index    <= row;
      req_column_index <= col;
      req_support_mask <= support;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and wait until every task sent so far has returned its result
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Write the device count only while the block is empty
   task automatic write_count(input logic [4:0] value);
      wait_idle();
      csr_valid        <= 1'b1;
      csr_device_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly small non-negative coordinates so the grid rules get exercised;
   // the rest are large, boundary or fully random (about half negative)
   function automatic logic [31:0] random_coord();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 32'($urandom_range(0, 40));
      if (pick < 70) return {1'b0, 31'($urandom)};
      if (pick < 80) begin
         case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return 32'($urandom);
   endfunction

   // Stimulus and verdict
   initial begin
      int p;
      int k;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_row_index    = '0;
      req_column_index = '0;
      req_support_mask = '0;
      csr_valid        = 1'b0;
      csr_device_count = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset value of the count is one device
      send_item(32'd2, 32'd3, 16'hFFFF);
      send_item(32'hFFFF_FFFF, 32'd0, 16'hFFFF);

      // Directed tasks with a count above the maximum, which saturates to 16
      write_count(5'd31);
      send_item(32'h0000_0000, 32'h0000_0000, 16'hFFFF);
      // largest coordinates; the chosen device is not in the support mask
      send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000);
      send_item(32'd15, 32'd0, 16'h0001);
      send_item(32'd0, 32'd15, 16'h8000);
      send_item(32'd15, 32'd15, 16'h1234);
      send_item(32'd16, 32'd17, 16'h00FF);
      send_item(32'd7, 32'd3, 16'h0F0F);
      send_item(32'd3, 32'd7, 16'hF0F0);
      // negative row, negative column, both negative: support mask fallback
      send_item(32'hFFFF_FFFF, 32'd5, 16'hFFFF);
      send_item(32'd5, 32'hFFFF_FFFF, 16'hA5A5);
      send_item(32'h8000_0000, 32'h8000_0000, 16'h5A5A);
      send_item(32'h8000_0000, 32'd0, 16'h0000);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);

      // Random tasks, one phase per device count
      for (p = 0; p < count_settings.size(); p++) begin
         write_count(5'(count_settings[p]));
         for (k = 0; k < ItemsPerPhase; k++) begin
            // long receiver hold-off while tasks keep coming: the pipeline
            // fills and the input must stall
            if (p == 3 && k == 5) hold_request = 1'b1;
            send_item(random_coord(), random_coord(), 16'($urandom));
         end
      end

      wait_idle();
      repeat (DrainCycles) @(posedge clock);

      $display("Run covered %0d tasks: %0d mapped to a grid cell, %0d support-mask fallbacks.",
               checked_count, mapped_count, checked_count - mapped_count);
      $display("Device counts 0 to 31 in %0d phases, bursty input, one %0d-cycle hold-off.",
               count_settings.size() + 2, HoldCycles);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Receiver: segments of random length, each with its own stall style
   initial begin
      int              seg_len;
      int              period;
      int              k;
      stall_style_type style;
      rsp_stall = 1'b0;
      forever begin
         seg_len = $urandom_range(8, 64);
         period  = $urandom_range(2, 5);
         style   = stall_style_type'($urandom_range(0, 3));
         if (hold_request) begin
            hold_request = 1'b0;
            seg_len      = HoldCycles;
            style        = STALL_HOLD;
         end
         for (k = 0; k < seg_len; k++) begin
            @(posedge clock);
            case (style)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
               STALL_PERIODIC: rsp_stall <= ((k % period) == 0);
               default:        rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   // Watchdog: abandon the run if it has not finished well past the slowest
   // plausible correct run
   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> block_cyclic_device_mapper_top.f
sv/bcdm_pkg.sv
sv/bcdm_cfg.sv
sv/bcdm_mod_stage.sv
sv/bcdm_entry.sv
sv/block_cyclic_device_mapper_top.sv
test/bcdm_mapping_checker.sv
test/tb_block_cyclic_device_mapper_top.sv
